// File: rtl/core/hbp_pkg.sv
// Shared types and constants for the Huffman table bit packer.
// No dependencies; every other file of the block refers to this package by scope.
package hbp_pkg;

    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int SYM_W  = 9;
    localparam int BYTE_W = 8;
    localparam int BUF_W  = CODE_W + BYTE_W;  // up to 7 pending bits plus one full code
    localparam int CNT_W  = 6;                // bit count in the packing buffer, 0..39

    localparam logic [SYM_W-1:0] END_SYMBOL = 9'd256;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ENCODE = 2'd1,
        KIND_FINISH = 2'd2
    } kind_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    // Looked-up item handed from the table stage to the packer.
    typedef struct packed {
        logic              is_encode;
        logic              is_finish;
        logic              has_code;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } item_t;

endpackage

// File: rtl/core/hbp_if.sv
// Channel interfaces of the Huffman table bit packer: input words and result words.
// Depends on hbp_pkg for field widths.
interface hbp_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [hbp_pkg::SYM_W-1:0]     symbol;
    logic [hbp_pkg::CODE_W-1:0]    code_bits;
    logic [hbp_pkg::LEN_W-1:0]     code_length;

    modport source (output valid, kind, symbol, code_bits, code_length, input ready);
    modport sink   (input valid, kind, symbol, code_bits, code_length, output ready);
endinterface

interface hbp_out_if;
    logic                          valid;
    logic                          ready;
    logic [hbp_pkg::BYTE_W-1:0]    out_byte;
    logic                          last;
    logic                          no_code_error;

    modport source (output valid, out_byte, last, no_code_error, input ready);
    modport sink   (input valid, out_byte, last, no_code_error, output ready);
endinterface

// File: rtl/core/hbp_table.sv
// Code table memory with post-reset clearing sweep, and the lookup stage register.
// Depends on hbp_pkg and hbp_if.
module hbp_table #(
    parameter int SYMBOL_COUNT = 257,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    hbp_in_if.sink         in_ch,
    output logic           item_valid,
    output hbp_pkg::item_t item,
    input  logic           item_take
);

    localparam int IDX_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int CAP      = (MAX_CODE_LEN < hbp_pkg::CODE_W) ? MAX_CODE_LEN : hbp_pkg::CODE_W;
    localparam int LAST_IDX = SYMBOL_COUNT - 1;

    hbp_pkg::entry_t mem [SYMBOL_COUNT];

    logic                       clr_active_reg;
    logic [IDX_W-1:0]           clr_idx_reg;
    logic                       s1_valid_reg;
    logic                       is_encode_reg;
    logic                       is_finish_reg;
    logic                       in_range_reg;
    hbp_pkg::entry_t            rd_entry_reg;

    logic                       accept;
    logic                       is_load;
    logic                       is_finish;
    logic [hbp_pkg::SYM_W-1:0]  addr_sym;
    logic                       in_range;
    logic [IDX_W-1:0]           idx;
    logic [hbp_pkg::LEN_W-1:0]  cap_len;
    logic [hbp_pkg::CODE_W-1:0] mask;
    hbp_pkg::entry_t            wr_entry;

    assign in_ch.ready = !clr_active_reg && (!s1_valid_reg || item_take);
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_load     = (in_ch.kind == hbp_pkg::KIND_LOAD);
    assign is_finish   = (in_ch.kind == hbp_pkg::KIND_FINISH);

    // finish looks up the end symbol
    assign addr_sym = is_finish ? hbp_pkg::END_SYMBOL : in_ch.symbol;
    assign in_range = (32'(addr_sym) < 32'(SYMBOL_COUNT));
    assign idx      = IDX_W'(addr_sym);

    assign cap_len  = (in_ch.code_length > hbp_pkg::LEN_W'(CAP))
                      ? hbp_pkg::LEN_W'(CAP) : in_ch.code_length;
    assign mask     = (cap_len >= hbp_pkg::LEN_W'(hbp_pkg::CODE_W))
                      ? '1 : ~({hbp_pkg::CODE_W{1'b1}} << cap_len);
    assign wr_entry = '{len: cap_len, code: in_ch.code_bits & mask};

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (accept && is_load && in_range)
        begin
            mem[idx] <= wr_entry;
        end
        if (accept)
        begin
            rd_entry_reg <= mem[idx];
        end
    end

    // one entry per cycle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_idx_reg == IDX_W'(LAST_IDX))
            begin
                clr_active_reg <= 1'b0;
            end
            else
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (item_take)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_encode_reg <= (in_ch.kind == hbp_pkg::KIND_ENCODE);
            is_finish_reg <= is_finish;
            in_range_reg  <= in_range;
        end
    end

    assign item_valid     = s1_valid_reg;
    assign item.is_encode = is_encode_reg;
    assign item.is_finish = is_finish_reg;
    assign item.has_code  = in_range_reg && (rd_entry_reg.len != '0);
    assign item.len       = rd_entry_reg.len;
    assign item.code      = rd_entry_reg.code;

endmodule

// File: rtl/core/hbp_packer.sv
// Bit packing buffer, byte emission sequencing and the result output register.
// Depends on hbp_pkg and hbp_if.
module hbp_packer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  hbp_pkg::item_t item,
    output logic           item_take,
    hbp_out_if.source      out_ch
);

    localparam int BW = hbp_pkg::BYTE_W;

    logic [hbp_pkg::BUF_W-1:0]  buf_reg, buf_next;
    logic [hbp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       fin_reg, fin_next;
    logic                       err_reg, err_next;
    logic                       out_valid_reg, out_valid_next;
    logic [BW-1:0]              out_byte_reg;
    logic                       out_last_reg;
    logic                       out_err_reg;

    logic                       busy;
    logic                       out_free;
    logic                       emit;
    logic [BW-1:0]              emit_byte;
    logic                       emit_last;
    logic                       emit_err;
    logic [hbp_pkg::CNT_W-1:0]  rem;
    logic [hbp_pkg::LEN_W-1:0]  left_sh;
    logic [hbp_pkg::CODE_W-1:0] code_left;
    logic [hbp_pkg::BUF_W-1:0]  placed;

    assign busy      = (cnt_reg >= hbp_pkg::CNT_W'(BW)) || fin_reg || err_reg;
    assign item_take = item_valid && !busy;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign rem       = cnt_reg - hbp_pkg::CNT_W'(BW);

    // code left aligned, then placed right after the pending bits
    assign left_sh   = hbp_pkg::LEN_W'(hbp_pkg::CODE_W) - item.len;
    assign code_left = item.code << left_sh;
    assign placed    = {code_left, {BW{1'b0}}} >> cnt_reg;

    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        fin_next  = fin_reg;
        err_next  = err_reg;
        emit      = 1'b0;
        emit_byte = '0;
        emit_last = 1'b0;
        emit_err  = 1'b0;
        if (item_take)
        begin
            if ((item.is_encode || item.is_finish) && item.has_code)
            begin
                buf_next = buf_reg | placed;
                cnt_next = cnt_reg + item.len;
            end
            if (item.is_finish)
            begin
                fin_next = 1'b1;
            end
            if ((item.is_encode || item.is_finish) && !item.has_code)
            begin
                err_next = 1'b1;
            end
        end
        else if (out_free)
        begin
            priority if (cnt_reg >= hbp_pkg::CNT_W'(BW))
            begin
                emit      = 1'b1;
                emit_byte = buf_reg[hbp_pkg::BUF_W-1 -: BW];
                emit_last = !((rem >= hbp_pkg::CNT_W'(BW)) || (fin_reg && rem != '0) || err_reg);
                buf_next  = buf_reg << BW;
                cnt_next  = rem;
            end
            else if (fin_reg)
            begin
                // flush partial byte, zero padded
                emit      = (cnt_reg != '0);
                emit_byte = buf_reg[hbp_pkg::BUF_W-1 -: BW];
                emit_last = !err_reg;
                buf_next  = '0;
                cnt_next  = '0;
                fin_next  = 1'b0;
            end
            else if (err_reg)
            begin
                emit      = 1'b1;
                emit_err  = 1'b1;
                emit_last = 1'b1;
                err_next  = 1'b0;
            end
            else
            begin
                emit      = 1'b0;    // idle, nothing pending
            end
        end
    end

    assign out_valid_next = out_free ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            cnt_reg       <= '0;
            fin_reg       <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            fin_reg       <= fin_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && out_free)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
            out_err_reg  <= emit_err;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_byte      = out_byte_reg;
    assign out_ch.last          = out_last_reg;
    assign out_ch.no_code_error = out_err_reg;

endmodule

// File: rtl/core/huffman_table_bit_packer.sv
// Huffman table bit packer: code table lookup stage feeding a byte packer.
// Path: lookup stage register, packing buffer, result register (a finish with no end code and
//   no pending bits also passes its flush step); then one result word per cycle unless stalled.
// Throughput: one input word per cycle for loads and encodes that fill no byte; an encode with
//   result words holds the packer until they are released; so does a finish, with its flush.
// Reset: table cleared one entry per cycle, all SYMBOL_COUNT entries; input ready low meanwhile.
module huffman_table_bit_packer #(
    parameter int SYMBOL_COUNT = 257,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    hbp_in_if.sink     item_in,
    hbp_out_if.source  result_out
);

    // Lookup stage -> packer hand-off.
    logic           item_valid;
    logic           item_take;
    hbp_pkg::item_t item;

    // Table stage: load words write the memory on acceptance; encode and finish
    // words read their entry (finish reads the end symbol) into a stage register.
    hbp_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (item_in),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Packer: merges the looked-up code behind the pending bits, then releases full bytes,
    // the finish flush and any error word one per cycle while the result output is free.
    hbp_packer u_packer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_ch     (result_out)
    );

endmodule
